// ===== src/acia_pkg.sv =====
// ----------------------------------------------------------------------------
// acia_pkg
// Shared types and constants for the serial interface register block.
// ----------------------------------------------------------------------------
package acia_pkg;

  typedef enum logic [1:0] {
    KIND_CPU_READ  = 2'd0,
    KIND_CPU_WRITE = 2'd1,
    KIND_HOST_PUSH = 2'd2,
    KIND_HOST_POP  = 2'd3
  } kind_t;

  localparam logic REG_STATUS = 1'b0;  // status on read, control on write
  localparam logic REG_DATA   = 1'b1;

  localparam logic [7:0] CTRL_MASTER_RESET = 8'h03;
  localparam int unsigned BYTE_W = 7;  // stored bytes are 7 bits wide

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;    // beat accepted: do pointer/flag updates, start store read
    logic finish;  // store read data valid: load result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_valid;   // result register occupied
    logic need_fetch;  // current input beat pops a ring
  } dp_status_t;

endpackage

// ===== src/acia_ram.sv =====
// ----------------------------------------------------------------------------
// acia_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module acia_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/acia_ctrl.sv =====
// ----------------------------------------------------------------------------
// acia_ctrl
// Sequencer: takes a beat, then waits in ST_FETCH for ring read data when needed.
// ----------------------------------------------------------------------------
module acia_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_ready,
  input  acia_pkg::dp_status_t  status,
  output acia_pkg::ctrl_cmd_t   cmd
);

  import acia_pkg::*;

  state_t state, state_next;
  logic   ready_int;

  // result register must be free (or emptying) before a new beat is taken
  assign ready_int = (state == ST_IDLE) && (!status.out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ready_int && in_valid && status.need_fetch) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = ready_int;
    cmd.take   = ready_int && in_valid;
    cmd.finish = (state == ST_FETCH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/acia_dp.sv =====
// ----------------------------------------------------------------------------
// acia_dp
// Ring pointers, flags, the two ring stores and the result register.
// ----------------------------------------------------------------------------
module acia_dp #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            in_user,
  input  logic [7:0]            in_data,
  input  logic                  out_ready,
  output logic [7:0]            out_value,
  output logic                  out_accepted,
  output logic                  out_valid,
  input  acia_pkg::ctrl_cmd_t   cmd,
  output acia_pkg::dp_status_t  status
);

  import acia_pkg::*;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);

  kind_t              kind;
  logic               sel;
  logic [RX_AW-1:0]   rx_wr_ptr, rx_rd_ptr, rx_wr_adv, rx_rd_adv;
  logic [TX_AW-1:0]   tx_wr_ptr, tx_rd_ptr, tx_wr_adv, tx_rd_adv;
  logic               rx_nodata, rx_full, tx_nodata, tx_full;
  logic               pop_rx, pop_tx, rx_we, tx_we, mreset;
  logic               push_drop, status_rd;
  logic               overrun;
  logic [BYTE_W-1:0]  last_byte;
  logic               fetch_rx;
  logic [BYTE_W-1:0]  rx_rdata, tx_rdata, wbyte;
  logic [7:0]         imm_value;
  logic               imm_accepted;

  assign kind  = kind_t'(in_user[1:0]);
  assign sel   = in_user[2];
  assign wbyte = in_data[BYTE_W-1:0];

  assign rx_wr_adv = (rx_wr_ptr == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr + 1'b1;
  assign rx_rd_adv = (rx_rd_ptr == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr + 1'b1;
  assign tx_wr_adv = (tx_wr_ptr == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr + 1'b1;
  assign tx_rd_adv = (tx_rd_ptr == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr + 1'b1;

  assign rx_nodata = (rx_wr_ptr == rx_rd_ptr);
  assign tx_nodata = (tx_wr_ptr == tx_rd_ptr);
  assign rx_full   = (rx_wr_adv == rx_rd_ptr);  // one slot kept free
  assign tx_full   = (tx_wr_adv == tx_rd_ptr);

  always_comb begin
    pop_rx    = (kind == KIND_CPU_READ) && (sel == REG_DATA) && !rx_nodata;
    pop_tx    = (kind == KIND_HOST_POP) && !tx_nodata;
    status_rd = (kind == KIND_CPU_READ) && (sel == REG_STATUS);
    mreset    = (kind == KIND_CPU_WRITE) && (sel == REG_STATUS)
                && (in_data == CTRL_MASTER_RESET);
    rx_we     = cmd.take && (kind == KIND_HOST_PUSH) && !rx_full;
    tx_we     = cmd.take && (kind == KIND_CPU_WRITE) && (sel == REG_DATA) && !tx_full;
    push_drop = (kind == KIND_HOST_PUSH) && rx_full;

    imm_value    = '0;
    imm_accepted = 1'b1;
    case (kind)
      KIND_CPU_READ: begin
        if (sel == REG_STATUS) begin
          imm_value = {3'b000, overrun, 2'b00, tx_nodata, !rx_nodata};
        end else begin
          imm_value = {1'b0, last_byte};
        end
      end
      KIND_HOST_PUSH: imm_accepted = !rx_full;
      KIND_HOST_POP:  imm_accepted = 1'b0;  // only reached when ring empty
      default:        imm_accepted = 1'b1;
    endcase
  end

  assign status.out_valid  = out_valid;
  assign status.need_fetch = pop_rx || pop_tx;

  // read address is the current read pointer; data arrives the next cycle
  acia_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr_ptr),
    .wdata (wbyte),
    .raddr (rx_rd_ptr),
    .rdata (rx_rdata)
  );

  acia_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr_ptr),
    .wdata (wbyte),
    .raddr (tx_rd_ptr),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wr_ptr <= '0;
      rx_rd_ptr <= '0;
      tx_wr_ptr <= '0;
      tx_rd_ptr <= '0;
      overrun   <= 1'b0;
      last_byte <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (mreset) begin
          // last_byte survives a master reset
          rx_wr_ptr <= '0;
          rx_rd_ptr <= '0;
          tx_wr_ptr <= '0;
          tx_rd_ptr <= '0;
          overrun   <= 1'b0;
        end else begin
          if (rx_we)     rx_wr_ptr <= rx_wr_adv;
          if (pop_rx)    rx_rd_ptr <= rx_rd_adv;
          if (tx_we)     tx_wr_ptr <= tx_wr_adv;
          if (pop_tx)    tx_rd_ptr <= tx_rd_adv;
          if (push_drop) overrun   <= 1'b1;
          if (status_rd) overrun   <= 1'b0;
        end
      end
      if (cmd.finish && fetch_rx) begin
        last_byte <= rx_rdata;
      end
      if ((cmd.take && !(pop_rx || pop_tx)) || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      fetch_rx <= pop_rx;
      if (!(pop_rx || pop_tx)) begin
        out_value    <= imm_value;
        out_accepted <= imm_accepted;
      end
    end
    if (cmd.finish) begin
      out_value    <= {1'b0, fetch_rx ? rx_rdata : tx_rdata};
      out_accepted <= 1'b1;
    end
  end

endmodule

// ===== src/acia_registers_with_fifos_top.sv =====
// ----------------------------------------------------------------------------
// acia_registers_with_fifos_top
// Serial interface register block with receive and transmit rings.
// ----------------------------------------------------------------------------
//  channel | dir | tdata            | tuser
//  s_axis  | in  | [7:0] data       | [1:0] kind, [2] reg_select
//  m_axis  | out | [7:0] value      | [0] accepted
//
//  One result beat per input beat. Accesses without a ring pop load the
//  result register directly; a ring pop waits in ST_FETCH for the registered
//  RAM read. Result sits in an output register; a new beat is taken while
//  it is being drained. Synchronous reset clears pointers, flags, last byte.
// ----------------------------------------------------------------------------
module acia_registers_with_fifos_top #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data
  input  logic [2:0] s_axis_tuser,   // [1:0] kind, [2] reg_select
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] value
  output logic [0:0] m_axis_tuser    // [0] accepted
);

  import acia_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  acia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  acia_dp #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_user      (s_axis_tuser),
    .in_data      (s_axis_tdata),
    .out_ready    (m_axis_tready),
    .out_value    (m_axis_tdata),
    .out_accepted (m_axis_tuser[0]),
    .out_valid    (m_axis_tvalid),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== bench/tb_acia_registers_with_fifos_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_acia_registers_with_fifos_top
// Self-checking bench for the serial interface register block. Directed
// register and ring accesses, then bursts of random beats that fill, drain,
// overflow and master-reset both rings. Random gaps on both sides, one long
// receiver hold-off. Replies are predicted in order and compared field by
// field.
// ----------------------------------------------------------------------------
module tb_acia_registers_with_fifos_top;
  import acia_pkg::*;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RANDOM_BEATS = 1550;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [7:0] value;
    logic       accepted;
  } reply_t;

  // Shadow of both rings and the status flags; predicts one reply per beat.
  class reply_tracker;
    logic [6:0] rx_ring[RX_DEPTH];
    logic [6:0] tx_ring[TX_DEPTH];
    int         rx_wr, rx_rd, tx_wr, tx_rd;
    logic       overrun;
    logic [6:0] last_byte;
    reply_t     pending_replies[$];
    int         errors, beats, rx_drops, tx_drops, resets, overrun_seen;

    function new();
      rx_wr = 0; rx_rd = 0; tx_wr = 0; tx_rd = 0;
      overrun = 1'b0;
      last_byte = 7'h00;
      errors = 0; beats = 0; rx_drops = 0; tx_drops = 0; resets = 0;
      overrun_seen = 0;
    endfunction

    function int step_ptr(int p, int depth);
      return (p + 1 >= depth) ? 0 : p + 1;
    endfunction

    function void predict_reply(kind_t k, logic sel, logic [7:0] d);
      reply_t r;
      logic   rx_nodata, tx_nodata;
      int     nxt;
      r.value = 8'h00;
      r.accepted = 1'b1;
      rx_nodata = (rx_wr == rx_rd);
      tx_nodata = (tx_wr == tx_rd);
      beats++;
      case (k)
        KIND_CPU_READ: begin
          if (sel == REG_STATUS) begin
            r.value = {3'b000, overrun, 2'b00, tx_nodata, !rx_nodata};
            if (overrun) overrun_seen++;
            overrun = 1'b0;
          end else if (rx_nodata) begin
            r.value = {1'b0, last_byte};
          end else begin
            r.value = {1'b0, rx_ring[rx_rd]};
            last_byte = rx_ring[rx_rd];
            rx_rd = step_ptr(rx_rd, RX_DEPTH);
          end
        end
        KIND_CPU_WRITE: begin
          if (sel == REG_STATUS) begin
            if (d == CTRL_MASTER_RESET) begin
              rx_wr = 0; rx_rd = 0; tx_wr = 0; tx_rd = 0;
              overrun = 1'b0;
              resets++;
            end
          end else begin
            nxt = step_ptr(tx_wr, TX_DEPTH);
            if (nxt != tx_rd) begin
              tx_ring[tx_wr] = d[6:0];
              tx_wr = nxt;
            end else begin
              tx_drops++;
            end
          end
        end
        KIND_HOST_PUSH: begin
          nxt = step_ptr(rx_wr, RX_DEPTH);
          if (nxt == rx_rd) begin
            overrun = 1'b1;
            r.accepted = 1'b0;
            rx_drops++;
          end else begin
            rx_ring[rx_wr] = d[6:0];
            rx_wr = nxt;
          end
        end
        default: begin
          if (tx_nodata) begin
            r.accepted = 1'b0;
          end else begin
            r.value = {1'b0, tx_ring[tx_rd]};
            tx_rd = step_ptr(tx_rd, TX_DEPTH);
          end
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [7:0] value, logic accepted);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $error("reply beat with no reply expected: value %0h accepted %0b", value, accepted);
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (value !== exp_r.value) begin
        $error("value mismatch: expected %0h, actual %0h", exp_r.value, value);
        errors++;
      end
      if (accepted !== exp_r.accepted) begin
        $error("accepted mismatch: expected %0b, actual %0b", exp_r.accepted, accepted);
        errors++;
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data
  logic [2:0] s_axis_tuser = 3'b000;  // [1:0] kind, [2] reg_select
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] value
  logic [0:0] m_axis_tuser;           // [0] accepted

  reply_tracker board = new();
  int           cycles = 0;
  int           beats_sent = 0;

  acia_registers_with_fifos_top #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, board.pending());
      $display("tb_acia_registers_with_fifos_top failed");
      $finish;
    end
  end

  // Input beat noted before the reply check; a reply can never belong to
  // the beat taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        board.predict_reply(kind_t'(s_axis_tuser[1:0]), s_axis_tuser[2], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        board.check_reply(m_axis_tdata, m_axis_tuser[0]);
    end
  end

  // Receiver: mostly short stalls, some long ready stretches, one long hold-off.
  initial begin
    int stretch;
    int r;
    stretch = 0;
    wait (!rst);
    forever begin
      stretch++;
      r = $urandom_range(0, 99);
      if (stretch == 40) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (r < 25) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_axis_tready <= 1'b0;
        if (r < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  function int pick_gap(bit no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // tvalid stays high between back-to-back beats
  task automatic send_beat(kind_t k, logic sel, logic [7:0] d, bit no_gaps);
    int gap;
    gap = pick_gap(no_gaps);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {sel, k};
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_random_beat(bit no_gaps);
    kind_t      k;
    logic       sel;
    logic [7:0] d;
    k   = kind_t'($urandom_range(0, 3));
    sel = 1'($urandom_range(0, 1));
    d   = 8'($urandom_range(0, 255));
    if (k == KIND_CPU_WRITE && sel == REG_STATUS && $urandom_range(0, 3) == 0)
      d = CTRL_MASTER_RESET;
    send_beat(k, sel, d, no_gaps);
  endtask

  // One burst leans on a single access so the rings run full or empty.
  task automatic random_burst();
    int         mode, len;
    bit         no_gaps;
    kind_t      k;
    logic       sel;
    mode    = $urandom_range(0, 9);
    no_gaps = ($urandom_range(0, 3) == 0);
    case (mode)
      0, 1: begin
        k = KIND_HOST_PUSH; sel = 1'($urandom_range(0, 1)); len = $urandom_range(40, 90);
      end
      2:    begin k = KIND_CPU_READ;  sel = REG_DATA;            len = $urandom_range(40, 80); end
      3:    begin k = KIND_CPU_WRITE; sel = REG_DATA;            len = $urandom_range(40, 90); end
      4: begin
        k = KIND_HOST_POP; sel = 1'($urandom_range(0, 1)); len = $urandom_range(40, 80);
      end
      default: begin k = KIND_CPU_READ; sel = REG_STATUS;         len = $urandom_range(10, 50); end
    endcase
    for (int i = 0; i < len; i++) begin
      if (mode <= 4 && $urandom_range(0, 99) < 85)
        send_beat(k, sel, 8'($urandom_range(0, 255)), no_gaps);
      else if (mode == 9)
        send_beat(KIND_CPU_READ, logic'(i % 2), 8'($urandom_range(0, 255)), no_gaps);
      else
        send_random_beat(no_gaps);
    end
    if (mode == 8)
      send_beat(KIND_CPU_WRITE, REG_STATUS, CTRL_MASTER_RESET, no_gaps);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty rings, masking, ignored control values, master reset
    send_beat(KIND_CPU_READ,  REG_STATUS, 8'h00, 1'b0);
    send_beat(KIND_CPU_READ,  REG_DATA,   8'hFF, 1'b0);
    send_beat(KIND_HOST_POP,  1'b1,       8'hFF, 1'b0);
    send_beat(KIND_CPU_WRITE, REG_DATA,   8'hFF, 1'b0);
    send_beat(KIND_CPU_READ,  REG_STATUS, 8'h00, 1'b0);
    send_beat(KIND_HOST_POP,  1'b0,       8'h00, 1'b0);
    send_beat(KIND_HOST_PUSH, 1'b0,       8'h00, 1'b0);
    send_beat(KIND_HOST_PUSH, 1'b1,       8'hFF, 1'b0);
    send_beat(KIND_CPU_READ,  REG_STATUS, 8'hAA, 1'b0);
    send_beat(KIND_CPU_READ,  REG_DATA,   8'h00, 1'b0);
    send_beat(KIND_CPU_READ,  REG_DATA,   8'h55, 1'b0);
    send_beat(KIND_CPU_READ,  REG_DATA,   8'h00, 1'b0);
    send_beat(KIND_CPU_WRITE, REG_STATUS, 8'h02, 1'b0);
    send_beat(KIND_CPU_WRITE, REG_STATUS, 8'hFF, 1'b0);
    send_beat(KIND_CPU_WRITE, REG_STATUS, 8'h83, 1'b0);
    send_beat(KIND_HOST_PUSH, 1'b0,       8'h55, 1'b0);
    send_beat(KIND_CPU_WRITE, REG_DATA,   8'h2A, 1'b0);
    send_beat(KIND_CPU_READ,  REG_STATUS, 8'h00, 1'b0);
    send_beat(KIND_CPU_WRITE, REG_STATUS, CTRL_MASTER_RESET, 1'b0);
    send_beat(KIND_CPU_READ,  REG_STATUS, 8'h00, 1'b0);
    send_beat(KIND_CPU_READ,  REG_DATA,   8'h00, 1'b0);
    send_beat(KIND_HOST_POP,  1'b1,       8'h00, 1'b0);
    send_beat(KIND_CPU_WRITE, REG_DATA,   8'h80, 1'b0);
    send_beat(KIND_HOST_POP,  1'b0,       8'h00, 1'b0);

    while (beats_sent < RANDOM_BEATS + 24)
      random_burst();
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d beats checked in %0d cycles: %0d master resets, %0d status reads with overrun",
             board.beats, cycles, board.resets, board.overrun_seen);
    $display("bytes dropped on full rings: %0d receive, %0d transmit",
             board.rx_drops, board.tx_drops);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_acia_registers_with_fifos_top passed");
    end else begin
      $display("tb_acia_registers_with_fifos_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/acia_pkg.sv
src/acia_ram.sv
src/acia_ctrl.sv
src/acia_dp.sv
src/acia_registers_with_fifos_top.sv
bench/tb_acia_registers_with_fifos_top.sv
